FILE: hw/rtl/lrd_pkg.sv
// Package for the DDA line rasterizer: grid width, working widths, the
// walker state encoding and the point record. No dependencies.
package lrd_pkg;

  // Grid coordinate width used inside the block; port fields stay six bits.
  localparam int COORD_BITS = 6;
  localparam int FIELD_W    = 6;

  // Signed width of the running numerator: holds remainder + 2*dminor.
  localparam int REM_W = COORD_BITS + 3;
  // Signed width of the interpolation quotient.
  localparam int QUO_W = COORD_BITS + 1;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic [FIELD_W-1:0]         field_t;
  typedef logic [COORD_BITS:0]        rem_t;
  typedef logic signed [REM_W-1:0]    acc_t;
  typedef logic signed [QUO_W-1:0]    quo_t;
  typedef logic signed [COORD_BITS+1:0] slope_t;
  typedef logic [COORD_BITS:0]        span_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK
  } walk_state_t;

  // One pixel offered by the walker to the output stage.
  typedef struct packed {
    logic   valid;
    coord_t x;
    coord_t y;
    logic   last;
  } point_t;

  // Zero-extend a grid coordinate to the port field width.
  function automatic field_t widen(coord_t c);
    return field_t'(c);
  endfunction

endpackage

FILE: hw/rtl/lrd_if.sv
// Channel interfaces of the line rasterizer: the line input and the pixel
// output, each with valid/ready. Depends on lrd_pkg.
interface lrd_line_if;
  logic               valid;
  logic               ready;
  lrd_pkg::field_t    start_x;
  lrd_pkg::field_t    start_y;
  lrd_pkg::field_t    end_x;
  lrd_pkg::field_t    end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lrd_pixel_if;
  logic               valid;
  logic               ready;
  lrd_pkg::field_t    pixel_x;
  lrd_pkg::field_t    pixel_y;
  logic               whole_block;
  logic               last_point;

  modport source (output valid, pixel_x, pixel_y, whole_block, last_point, input ready);
  modport sink   (input valid, pixel_x, pixel_y, whole_block, last_point, output ready);
endinterface

FILE: hw/rtl/lrd_interp_unit.sv
// Interpolation step: adds 2*dminor to the running remainder and
// folds it back into [0, 2n) with a quotient correction. Depends on lrd_pkg.
module lrd_interp_unit (
  input  lrd_pkg::rem_t   remainder,
  input  lrd_pkg::quo_t   quotient,
  input  lrd_pkg::slope_t twice_dm,
  input  lrd_pkg::span_t  twice_n,
  output lrd_pkg::rem_t   remainder_next,
  output lrd_pkg::quo_t   quotient_next
);
  import lrd_pkg::*;

  acc_t sum;
  acc_t span;
  acc_t folded;

  // Since |dminor| <= n, one step moves the quotient by at most one.
  always_comb begin
    sum  = $signed({2'b00, remainder}) + acc_t'(twice_dm);
    span = $signed({2'b00, twice_n});
    if (sum >= span) begin
      folded        = sum - span;
      quotient_next = quotient + quo_t'(1);
    end else if (sum < acc_t'(0)) begin
      folded        = sum + span;
      quotient_next = quotient - quo_t'(1);
    end else begin
      folded        = sum;
      quotient_next = quotient;
    end
    remainder_next = folded[COORD_BITS:0];
  end

endmodule

FILE: hw/rtl/lrd_walker.sv
// Line walker: captures one line, sets up the major axis, then steps one
// pixel per granted cycle using lrd_interp_unit. Depends on lrd_pkg, lrd_if.
module lrd_walker (
  input  logic             clk,
  input  logic             rst,
  lrd_line_if.sink         line,
  input  logic             take,
  output lrd_pkg::point_t  point
);
  import lrd_pkg::*;

  walk_state_t state;
  walk_state_t state_next;

  coord_t sx, sy, ex, ey;
  logic   x_major;
  logic   dir_down;
  coord_t major_position;
  coord_t major_end;
  coord_t minor_base;
  quo_t   quotient;
  rem_t   remainder;
  slope_t twice_dm;
  span_t  twice_n;

  // Setup terms derived from the captured endpoints.
  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic signed [COORD_BITS:0] dminor;
  coord_t adx;
  coord_t ady;
  coord_t steps;
  logic   xm;

  rem_t   remainder_next;
  quo_t   quotient_next;
  coord_t minor_pixel;
  logic   accept;
  logic   at_end;

  assign accept = line.valid && line.ready;
  assign line.ready = (state == ST_IDLE);

  always_comb begin
    dx     = $signed({1'b0, ex}) - $signed({1'b0, sx});
    dy     = $signed({1'b0, ey}) - $signed({1'b0, sy});
    adx    = coord_t'(dx[COORD_BITS] ? -dx : dx);
    ady    = coord_t'(dy[COORD_BITS] ? -dy : dy);
    xm     = (adx > ady);
    steps  = xm ? adx : ady;
    dminor = xm ? dy : dx;
  end

  lrd_interp_unit u_interp (
    .remainder      (remainder),
    .quotient       (quotient),
    .twice_dm       (twice_dm),
    .twice_n        (twice_n),
    .remainder_next (remainder_next),
    .quotient_next  (quotient_next)
  );

  // Current pixel of the walk.
  assign minor_pixel = minor_base + coord_t'(quotient);
  assign at_end      = (major_position == major_end);

  always_comb begin
    point.valid = (state == ST_WALK);
    point.x     = x_major ? major_position : minor_pixel;
    point.y     = x_major ? minor_pixel : major_position;
    point.last  = at_end;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (take && at_end) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Endpoint capture on an input transfer.
  always_ff @(posedge clk) begin
    if (accept) begin
      sx <= line.start_x[COORD_BITS-1:0];
      sy <= line.start_y[COORD_BITS-1:0];
      ex <= line.end_x[COORD_BITS-1:0];
      ey <= line.end_y[COORD_BITS-1:0];
    end
  end

  // Walk registers: loaded in setup, advanced on each granted pixel but the last.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_major        <= 1'b0;
      dir_down       <= 1'b0;
      major_position <= '0;
      major_end      <= '0;
      minor_base     <= '0;
      quotient       <= '0;
      remainder      <= '0;
      twice_dm       <= '0;
      twice_n        <= '0;
    end else if (state == ST_SETUP) begin
      x_major        <= xm;
      dir_down       <= xm ? dx[COORD_BITS] : dy[COORD_BITS];
      major_position <= xm ? sx : sy;
      major_end      <= xm ? ex : ey;
      minor_base     <= xm ? sy : sx;
      quotient       <= '0;
      remainder      <= {1'b0, steps};
      twice_dm       <= {dminor, 1'b0};
      twice_n        <= {steps, 1'b0};
    end else if (state == ST_WALK && take && !at_end) begin
      major_position <= dir_down ? major_position - coord_t'(1)
                                 : major_position + coord_t'(1);
      quotient       <= quotient_next;
      remainder      <= remainder_next;
    end
  end

  // The remainder always stays below 2n while steps remain.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && !at_end) |-> (remainder < twice_n))
    else $error("walker remainder out of range");

  // A granted final pixel ends the line.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && take && at_end) |=> (state == ST_IDLE))
    else $error("walker did not return to idle after the last pixel");

  // Setup is always followed directly by the walk.
  a_setup_once: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SETUP) |=> (state == ST_WALK))
    else $error("walker setup did not advance");

  // Without a grant the walk position holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK && !take) |=> $stable(major_position) && $stable(quotient))
    else $error("walker advanced without a grant");

endmodule

FILE: hw/rtl/line_rasterizer_dda.sv
// DDA line rasterizer. One line transfer gives 1 + max(|dx|,|dy|) pixel
// transfers, the start point first and last_point set on the final one. The
// block takes the line, sets up the major axis, then walks one pixel per
// cycle from the interpolation step unit while the output register is free
// or the pixel sink holds ready high. The next line is taken once the last
// pixel has been handed to the output register. window_mode is sampled as
// each pixel enters the output register and is meant to change only while
// the block is idle.
// Depends on lrd_pkg, lrd_if, lrd_walker and lrd_interp_unit.
module line_rasterizer_dda (
  input  logic        clk,
  input  logic        rst,
  lrd_line_if.sink    line,
  lrd_pixel_if.source pixel,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  import lrd_pkg::*;

  logic   window_mode;
  point_t point;
  logic   take;

  logic   out_valid;
  field_t out_x;
  field_t out_y;
  logic   out_block;
  logic   out_last;

  lrd_walker u_walker (
    .clk   (clk),
    .rst   (rst),
    .line  (line),
    .take  (take),
    .point (point)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_mode <= 1'b0;
    end else if (cfg_we) begin
      window_mode <= cfg_wdata;
    end
  end

  // The walker advances whenever the output register is free or draining.
  assign take = point.valid && (!out_valid || pixel.ready);

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (pixel.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (take) begin
      out_x     <= widen(point.x);
      out_y     <= widen(point.y);
      out_block <= window_mode;
      out_last  <= point.last;
    end
  end

  assign pixel.valid       = out_valid;
  assign pixel.pixel_x     = out_x;
  assign pixel.pixel_y     = out_y;
  assign pixel.whole_block = out_block;
  assign pixel.last_point  = out_last;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the DDA line rasterizer: line transfers in, pixel transfers out.
// Depends on lrd_pkg, the lrd_line_if/lrd_pixel_if interfaces and line_rasterizer_dda.
`timescale 1ns / 1ps

module testbench;
  import lrd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    field_t sx;
    field_t sy;
    field_t ex;
    field_t ey;
  } line_rec_t;

  typedef struct {
    field_t x;
    field_t y;
    logic   blk;
    logic   last;
  } pixel_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Local copies of every block input, known from time zero.
  logic   line_valid = 1'b0;
  field_t line_sx = '0;
  field_t line_sy = '0;
  field_t line_ex = '0;
  field_t line_ey = '0;
  logic   pixel_ready = 1'b0;
  logic   cfg_we = 1'b0;
  logic   cfg_wdata = 1'b0;

  logic window_now = 1'b0;
  logic quiet = 1'b0;

  line_rec_t  line_q[$];
  pixel_rec_t pix_expect[$];

  int lines_sent = 0;
  int pixels_seen = 0;
  int mismatches = 0;
  int settings_applied = 0;
  int stall_cycles = 0;

  lrd_line_if  line ();
  lrd_pixel_if pixel ();

  assign line.valid   = line_valid;
  assign line.start_x = line_sx;
  assign line.start_y = line_sy;
  assign line.end_x   = line_ex;
  assign line.end_y   = line_ey;
  assign pixel.ready  = pixel_ready;

  line_rasterizer_dda dut (
    .clk       (clk),
    .rst       (rst),
    .line      (line),
    .pixel     (pixel),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Walk the line exactly as the block should and queue every pixel it owes.
  task automatic expect_pixels(input line_rec_t ln, input logic blk);
    int cm, sx, sy, ex, ey, dx, dy, adx, ady, steps, dir, dminor;
    int num, den, q, k, major, minor;
    bit xmaj;
    pixel_rec_t p;
    cm = (1 << COORD_BITS) - 1;
    sx = ln.sx & cm;
    sy = ln.sy & cm;
    ex = ln.ex & cm;
    ey = ln.ey & cm;
    dx = ex - sx;
    dy = ey - sy;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    xmaj = adx > ady;
    steps = xmaj ? adx : ady;
    dir = xmaj ? (dx < 0 ? -1 : 1) : (dy < 0 ? -1 : 1);
    dminor = xmaj ? dy : dx;
    p.x = field_t'(sx);
    p.y = field_t'(sy);
    p.blk = blk;
    p.last = (steps == 0);
    pix_expect.push_back(p);
    for (k = 1; k <= steps; k++) begin
      // Round to nearest with ties upward, using a floor division.
      num = 2 * dminor * k + steps;
      den = 2 * steps;
      q = num >= 0 ? num / den : -((-num + den - 1) / den);
      major = (xmaj ? sx : sy) + dir * k;
      minor = (xmaj ? sy : sx) + q;
      p.x = field_t'((xmaj ? major : minor) & cm);
      p.y = field_t'((xmaj ? minor : major) & cm);
      p.last = (k == steps);
      pix_expect.push_back(p);
    end
  endtask

  function automatic line_rec_t make_line(input int sx, input int sy, input int ex,
                                          input int ey);
    line_rec_t ln;
    ln.sx = field_t'(sx);
    ln.sy = field_t'(sy);
    ln.ex = field_t'(ex);
    ln.ey = field_t'(ey);
    return ln;
  endfunction

  // A coordinate a few cells away from c, kept on the grid.
  function automatic int nearby(input int c);
    int v;
    v = c + $urandom_range(16) - 8;
    if (v < 0) v = 0;
    if (v > 63) v = 63;
    return v;
  endfunction

  // Mostly short lines, some across the grid, some degenerate, axis-aligned or diagonal.
  task automatic add_random_lines(input int count);
    int i, pick, sx, sy, d;
    for (i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      sx = $urandom_range(63);
      sy = $urandom_range(63);
      if (pick < 55) begin
        line_q.push_back(make_line(sx, sy, nearby(sx), nearby(sy)));
      end else if (pick < 80) begin
        line_q.push_back(make_line(sx, sy, $urandom_range(63), $urandom_range(63)));
      end else if (pick < 90) begin
        line_q.push_back(make_line(sx, sy, sx, sy));
      end else if (pick < 94) begin
        line_q.push_back(make_line(sx, sy, nearby(sx), sy));
      end else if (pick < 97) begin
        line_q.push_back(make_line(sx, sy, sx, nearby(sy)));
      end else begin
        d = $urandom_range(8);
        line_q.push_back(make_line(sx, sy, sx >= 32 ? sx - d : sx + d,
                                   sy >= 32 ? sy - d : sy + d));
      end
    end
  endtask

  task automatic wait_drained();
    while (line_q.size() != 0 || line_valid || pix_expect.size() != 0)
      @(posedge clk);
  endtask

  // Change the window setting only once the block has gone idle.
  task automatic set_window(input logic v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    window_now <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Line driver: holds an offered line until its transfer, idles at random.
  always @(posedge clk) begin
    if (rst) begin
      line_valid <= 1'b0;
    end else begin
      if (line_valid && line.ready) begin
        expect_pixels(line_q[0], window_now);
        void'(line_q.pop_front());
        lines_sent++;
      end
      if (line_valid && !line.ready) begin
        line_valid <= 1'b1;
      end else if (line_q.size() != 0 && (quiet || $urandom_range(99) >= 14)) begin
        line_valid <= 1'b1;
        line_sx <= line_q[0].sx;
        line_sy <= line_q[0].sy;
        line_ex <= line_q[0].ex;
        line_ey <= line_q[0].ey;
      end else begin
        line_valid <= 1'b0;
      end
    end
  end

  // Pixel monitor: checks each pixel transfer against the oldest expectation.
  always @(posedge clk) begin : check_pixels
    pixel_rec_t want;
    if (rst) begin
      pixel_ready <= 1'b0;
    end else begin
      if (pixel.valid && pixel_ready) begin
        pixels_seen++;
        if (pix_expect.size() == 0) begin
          if (mismatches < 10)
            $display("pixel %0d unexpected: x=%0d y=%0d blk=%0b last=%0b", pixels_seen,
                     pixel.pixel_x, pixel.pixel_y, pixel.whole_block, pixel.last_point);
          mismatches++;
        end else begin
          want = pix_expect.pop_front();
          if (pixel.pixel_x !== want.x || pixel.pixel_y !== want.y ||
              pixel.whole_block !== want.blk || pixel.last_point !== want.last) begin
            if (mismatches < 10)
              $display("pixel %0d mismatch: expected x=%0d y=%0d blk=%0b last=%0b, got x=%0d y=%0d blk=%0b last=%0b",
                       pixels_seen, want.x, want.y, want.blk, want.last, pixel.pixel_x,
                       pixel.pixel_y, pixel.whole_block, pixel.last_point);
            mismatches++;
          end
        end
      end
      pixel_ready <= quiet || $urandom_range(99) >= 14;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((line_valid && line.ready) || (pixel.valid && pixel_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles with no transfer", STALL_LIMIT);
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed lines: extremes, axis and diagonal cases, rounding ties.
    set_window(1'b0);
    line_q.push_back(make_line(0, 0, 0, 0));
    line_q.push_back(make_line(63, 63, 63, 63));
    line_q.push_back(make_line(0, 0, 63, 0));
    line_q.push_back(make_line(63, 0, 0, 0));
    line_q.push_back(make_line(0, 0, 0, 63));
    line_q.push_back(make_line(0, 63, 0, 0));
    line_q.push_back(make_line(0, 0, 63, 63));
    line_q.push_back(make_line(63, 63, 0, 0));
    line_q.push_back(make_line(0, 63, 63, 0));
    line_q.push_back(make_line(0, 0, 63, 1));
    line_q.push_back(make_line(0, 0, 1, 63));
    line_q.push_back(make_line(10, 10, 14, 12));
    line_q.push_back(make_line(10, 10, 14, 8));
    line_q.push_back(make_line(12, 10, 10, 14));
    line_q.push_back(make_line(5, 5, 6, 5));
    line_q.push_back(make_line(5, 5, 5, 4));
    line_q.push_back(make_line(20, 30, 50, 17));
    line_q.push_back(make_line(0, 63, 63, 62));
    line_q.push_back(make_line(42, 21, 21, 42));
    line_q.push_back(make_line(21, 42, 42, 21));

    // Random phases across both window settings; the first has no idling.
    set_window(1'b1);
    quiet <= 1'b1;
    add_random_lines(95);
    wait_drained();
    quiet <= 1'b0;
    set_window(1'b0);
    add_random_lines(100);
    set_window(1'b1);
    add_random_lines(95);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("ran %0d lines giving %0d pixels across %0d window settings",
             lines_sent, pixels_seen, settings_applied);
    if (mismatches == 0 && pix_expect.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
